>>> hdl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg: shared types, constants and font for the text framebuffer
// Request codes, the fill command type and the 5x7 glyph table.
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;

    localparam logic [2:0] REQ_PIXEL = 3'd0;
    localparam logic [2:0] REQ_CHAR  = 3'd1;
    localparam logic [2:0] REQ_SCHAR = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    localparam logic [7:0] CODE_FIRST = 8'd32;
    localparam logic [7:0] CODE_LAST  = 8'd126;

    // pixel walker command
    typedef struct packed {
        logic              go;
        logic signed [12:0] x0;
        logic signed [12:0] y0;
        logic        [7:0]  w;
        logic        [7:0]  h;
        logic              on;
    } t_fill_cmd;

    function automatic logic [39:0] glyph(input logic [7:0] code);
        logic [39:0] g;
        case (code)
            8'd33:  g = 40'h00005F0000;
            8'd34:  g = 40'h0007000700;
            8'd35:  g = 40'h147F147F14;
            8'd36:  g = 40'h242A7F2A12;
            8'd37:  g = 40'h2313086462;
            8'd38:  g = 40'h3649552250;
            8'd39:  g = 40'h0005030000;
            8'd40:  g = 40'h001C224100;
            8'd41:  g = 40'h0041221C00;
            8'd42:  g = 40'h14083E0814;
            8'd43:  g = 40'h08083E0808;
            8'd44:  g = 40'h0050300000;
            8'd45:  g = 40'h0808080808;
            8'd46:  g = 40'h0060600000;
            8'd47:  g = 40'h2010080402;
            8'd48:  g = 40'h3E5149453E;
            8'd49:  g = 40'h00427F4000;
            8'd50:  g = 40'h4261514946;
            8'd51:  g = 40'h2141454B31;
            8'd52:  g = 40'h1814127F10;
            8'd53:  g = 40'h2745454539;
            8'd54:  g = 40'h3C4A494930;
            8'd55:  g = 40'h0171090503;
            8'd56:  g = 40'h3649494936;
            8'd57:  g = 40'h064949291E;
            8'd58:  g = 40'h0011001100;
            8'd60:  g = 40'h0814224100;
            8'd61:  g = 40'h1414141414;
            8'd62:  g = 40'h0041221408;
            8'd63:  g = 40'h0201510906;
            8'd65:  g = 40'h7E1111117E;
            8'd66:  g = 40'h7F49494936;
            8'd67:  g = 40'h3E41414122;
            8'd68:  g = 40'h7F4141221C;
            8'd69:  g = 40'h7F49494941;
            8'd70:  g = 40'h7F09090901;
            8'd71:  g = 40'h3E4149497A;
            8'd72:  g = 40'h7F0808087F;
            8'd73:  g = 40'h00417F4100;
            8'd74:  g = 40'h2040413F01;
            8'd75:  g = 40'h7F08142241;
            8'd76:  g = 40'h7F40404040;
            8'd77:  g = 40'h7F020C027F;
            8'd78:  g = 40'h7F0408107F;
            8'd79:  g = 40'h3E4141413E;
            8'd80:  g = 40'h7F09090906;
            8'd81:  g = 40'h3E4151215E;
            8'd82:  g = 40'h7F09192946;
            8'd83:  g = 40'h4649494931;
            8'd84:  g = 40'h01017F0101;
            8'd85:  g = 40'h3F4040403F;
            8'd86:  g = 40'h1F2040201F;
            8'd87:  g = 40'h3F4038403F;
            8'd88:  g = 40'h6314081463;
            8'd89:  g = 40'h0708700807;
            8'd90:  g = 40'h6151494543;
            8'd97:  g = 40'h2054545478;
            8'd98:  g = 40'h7F48444438;
            8'd99:  g = 40'h3844444420;
            8'd100: g = 40'h384444487F;
            8'd101: g = 40'h3854545418;
            8'd102: g = 40'h087E090102;
            8'd103: g = 40'h0C5252523E;
            8'd104: g = 40'h7F08040478;
            8'd105: g = 40'h00447D4000;
            8'd106: g = 40'h2040443D00;
            8'd107: g = 40'h7F10284400;
            8'd108: g = 40'h00417F4000;
            8'd109: g = 40'h7C04180478;
            8'd110: g = 40'h7C08040478;
            8'd111: g = 40'h3844444438;
            8'd112: g = 40'h7C14141408;
            8'd113: g = 40'h081414187C;
            8'd114: g = 40'h7C08040408;
            8'd115: g = 40'h4854545420;
            8'd116: g = 40'h043F444020;
            8'd117: g = 40'h3C4040207C;
            8'd118: g = 40'h1C2040201C;
            8'd119: g = 40'h3C4030403C;
            8'd120: g = 40'h4428102844;
            8'd121: g = 40'h0C5050503C;
            8'd122: g = 40'h4464544C44;
            default: g = 40'h0;
        endcase
        return g;
    endfunction

endpackage

>>> hdl/mtf_fill.sv
// ----------------------------------------------------------------------------
// mtf_fill: rectangle pixel walker
// Steps one pixel per cycle over a w by h block, clips, and issues a
// read-modify-write request per pixel to the store.
// ----------------------------------------------------------------------------
module mtf_fill #(
    parameter int SCREEN_WIDTH  = mtf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = mtf_pkg::DEF_SCREEN_HEIGHT,
    localparam int XW = $clog2(SCREEN_WIDTH),
    localparam int YW = $clog2(SCREEN_HEIGHT)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtf_pkg::t_fill_cmd i_cmd,
    output logic              o_busy,
    output logic              o_wr,
    output logic [XW-1:0]     o_x,
    output logic [YW-1:0]     o_y,
    output logic              o_on
);
    import mtf_pkg::*;

    logic               r_act;
    logic signed [12:0] r_x0, r_y0;
    logic [7:0]         r_w, r_h, r_dx, r_dy;
    logic               r_on;
    logic signed [13:0] px, py;
    logic               last;

    assign px = 14'(r_x0) + 14'($signed({1'b0, r_dx}));
    assign py = 14'(r_y0) + 14'($signed({1'b0, r_dy}));
    assign last = (r_dy == r_h - 8'd1) && (r_dx == r_w - 8'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_cmd.go) begin
            r_act <= (i_cmd.w != 8'd0) && (i_cmd.h != 8'd0);
        end else if (r_act && last) begin
            r_act <= 1'b0;
        end
        if (i_cmd.go) begin
            r_x0 <= i_cmd.x0;
            r_y0 <= i_cmd.y0;
            r_w  <= i_cmd.w;
            r_h  <= i_cmd.h;
            r_on <= i_cmd.on;
            r_dx <= '0;
            r_dy <= '0;
        end else if (r_act) begin
            if (r_dy == r_h - 8'd1) begin
                r_dy <= '0;
                r_dx <= r_dx + 8'd1;
            end else begin
                r_dy <= r_dy + 8'd1;
            end
        end
    end

    assign o_busy = r_act;
    assign o_wr   = r_act && px >= 0 && px < 14'(SCREEN_WIDTH)
                    && py >= 0 && py < 14'(SCREEN_HEIGHT);
    assign o_x    = px[XW-1:0];
    assign o_y    = py[YW-1:0];
    assign o_on   = r_on;
endmodule

>>> hdl/mtf_store.sv
// ----------------------------------------------------------------------------
// mtf_store: page-organised frame memory
// Bit set/clear by two-stage read-modify-write with forwarding, byte reads,
// and a one-byte-per-cycle clearing sweep.
// ----------------------------------------------------------------------------
module mtf_store #(
    parameter int SCREEN_WIDTH  = mtf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = mtf_pkg::DEF_SCREEN_HEIGHT,
    localparam int XW = $clog2(SCREEN_WIDTH),
    localparam int YW = $clog2(SCREEN_HEIGHT),
    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8,
    localparam int BYTES = SCREEN_WIDTH * PAGES,
    localparam int AW = $clog2(BYTES)
) (
    input  logic          i_clk,
    input  logic          i_wr,
    input  logic [XW-1:0] i_x,
    input  logic [YW-1:0] i_y,
    input  logic          i_on,
    input  logic          i_clr,
    input  logic [AW-1:0] i_clr_addr,
    input  logic          i_rd,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    output logic          o_idle
);
    import mtf_pkg::*;

    logic [7:0]    mem [BYTES];
    logic [AW-1:0] a_addr, r_addr;
    logic [2:0]    r_bit;
    logic          r_on, r_wr;
    logic [7:0]    r_q, r_last, cur, upd;
    logic          r_last_v;
    logic [AW-1:0] r_last_a;

    assign a_addr = i_rd ? i_rd_addr
                  : AW'(32'(i_y >> 3) * SCREEN_WIDTH + 32'(i_x));

    always_ff @(posedge i_clk) begin
        r_q    <= mem[a_addr];
        r_addr <= a_addr;
        r_bit  <= 3'(i_y);
        r_on   <= i_on;
        r_wr   <= i_wr;
        if (i_clr) begin
            mem[i_clr_addr] <= 8'd0;
        end else if (r_wr) begin
            mem[r_addr] <= upd;
        end
        r_last_v <= r_wr;
        r_last_a <= r_addr;
        r_last   <= upd;
    end

    assign cur = (r_last_v && r_last_a == r_addr) ? r_last : r_q;
    always_comb begin
        upd = cur;
        upd[r_bit] = r_on;
    end
    assign o_rd_data = r_q;
    assign o_idle    = !r_wr;
endmodule

>>> hdl/mono_text_framebuffer.sv
// ----------------------------------------------------------------------------
// mono_text_framebuffer: page-addressed monochrome framebuffer with 5x7 font
// Sequencer that breaks pixel, char and scaled-char requests into filled
// blocks for the pixel walker, plus clear and byte read.
//
//  channel  | ports                                    | direction
//  request  | i_start/o_busy, i_req_type..i_read_index | in
//  result   | o_done, o_read_data, o_char_ignored      | out
//
// Unused request codes and ignored chars finish without drawing. A char is
// drawn as 35 blocks, one per glyph pixel, of s by s pixels; a scaled char
// adds a cleared spacing column of s by 7*s pixels.
// Clear and reset: one byte per cycle over the whole store; busy meanwhile.
// o_done is high in the first cycle with busy low after each request, but
// not after the reset clear; the receiver cannot stall.
// ----------------------------------------------------------------------------
module mono_text_framebuffer #(
    parameter int SCREEN_WIDTH  = mtf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = mtf_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_req_type,
    input  logic signed [10:0] i_x_pos,
    input  logic signed [10:0] i_y_pos,
    input  logic        i_pixel_on,
    input  logic [7:0]  i_char_code,
    input  logic [3:0]  i_scale,
    input  logic [9:0]  i_read_index,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic        o_char_ignored
);
    import mtf_pkg::*;

    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);
    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int BYTES = SCREEN_WIDTH * PAGES;
    localparam int AW = $clog2(BYTES);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_ISSUE = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_READ  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state       r_state;
    logic [AW:0]  r_ca;
    logic [2:0]   r_kind;
    logic signed [12:0] r_y, r_bx, r_by;
    logic         r_on;
    logic [39:0]  r_g;
    logic [3:0]   r_s;
    logic [7:0]   r_sz;
    logic [2:0]   r_col, r_row;
    logic         r_tail;
    logic [9:0]   r_ridx;
    logic         r_ign, r_done, r_rd_ok;
    logic [7:0]   r_rd;
    t_fill_cmd    cmd;
    logic         f_busy, f_wr, f_on, st_idle;
    logic [XW-1:0] f_x;
    logic [YW-1:0] f_y;
    logic [7:0]   st_q;
    logic         printable;
    logic         clr_last;

    assign printable = i_char_code >= CODE_FIRST && i_char_code <= CODE_LAST;
    assign clr_last  = (r_ca == (AW+1)'(BYTES - 1));

    always_comb begin
        cmd    = '0;
        cmd.go = (r_state == S_ISSUE);
        cmd.x0 = r_bx;
        cmd.y0 = r_by;
        cmd.w  = r_sz;
        cmd.h  = r_tail ? 8'(7 * r_sz) : r_sz;
        cmd.on = r_tail ? 1'b0 : (r_kind == REQ_PIXEL ? r_on
                 : r_g[{3'd4 - r_col, r_row}]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == S_DONE)
                      || (r_state == S_CLEAR && clr_last && r_kind == REQ_CLEAR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ca    <= '0;
            r_kind  <= REQ_PIXEL;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_ca <= r_ca + 1'b1;
                    if (clr_last) begin
                        r_state <= S_IDLE;
                        r_ign   <= 1'b0;
                        r_rd    <= 8'd0;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_kind <= i_req_type;
                        r_y    <= 13'(i_y_pos);
                        r_bx   <= 13'(i_x_pos);
                        r_by   <= 13'(i_y_pos);
                        r_on   <= i_pixel_on;
                        r_g    <= glyph(i_char_code);
                        r_col  <= '0;
                        r_row  <= '0;
                        r_tail <= 1'b0;
                        r_ridx <= i_read_index;
                        r_ign  <= (i_req_type == REQ_CHAR || i_req_type == REQ_SCHAR)
                                  && !printable;
                        r_rd   <= 8'd0;
                        r_s    <= (i_req_type == REQ_SCHAR && i_scale != 4'd0)
                                  ? i_scale : 4'd1;
                        r_sz   <= (i_req_type == REQ_SCHAR && i_scale != 4'd0)
                                  ? 8'(i_scale) : 8'd1;
                        case (i_req_type)
                            REQ_PIXEL: r_state <= S_ISSUE;
                            REQ_CHAR, REQ_SCHAR: begin
                                if (printable) begin
                                    r_state <= S_ISSUE;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            REQ_CLEAR: begin
                                r_ca    <= '0;
                                r_state <= S_CLEAR;
                            end
                            REQ_READ: r_state <= S_READ;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (!f_busy) begin
                        if (r_kind == REQ_PIXEL || r_tail) begin
                            r_state <= S_DRAIN;
                        end else if (r_row != 3'd6) begin
                            r_row   <= r_row + 3'd1;
                            r_by    <= r_by + 13'(r_s);
                            r_state <= S_ISSUE;
                        end else if (r_col != 3'd4) begin
                            r_row   <= '0;
                            r_col   <= r_col + 3'd1;
                            r_by    <= r_y;
                            r_bx    <= r_bx + 13'(r_s);
                            r_state <= S_ISSUE;
                        end else if (r_kind == REQ_SCHAR) begin
                            r_tail  <= 1'b1;
                            r_by    <= r_y;
                            r_bx    <= r_bx + 13'(r_s);
                            r_state <= S_ISSUE;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: if (st_idle) r_state <= S_DONE;
                S_READ: begin
                    r_rd_ok <= 32'(r_ridx) < BYTES;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (r_kind == REQ_READ && r_rd_ok) r_rd <= st_q;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_IDLE && i_start) r_rd_ok <= 1'b0;
        end
    end

    mtf_fill #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_busy  (f_busy),
        .o_wr    (f_wr),
        .o_x     (f_x),
        .o_y     (f_y),
        .o_on    (f_on)
    );

    mtf_store #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_store (
        .i_clk      (i_clk),
        .i_wr       (f_wr),
        .i_x        (f_x),
        .i_y        (f_y),
        .i_on       (f_on),
        .i_clr      (r_state == S_CLEAR),
        .i_clr_addr (r_ca[AW-1:0]),
        .i_rd       (r_state == S_READ),
        .i_rd_addr  (r_ridx[AW-1:0]),
        .o_rd_data  (st_q),
        .o_idle     (st_idle)
    );

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_read_data    = r_rd;
    assign o_char_ignored = r_ign;
endmodule
